@@ design/lsps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Launch pitch solver package
// Shared constants and the arctangent table for the drag-free pitch solver.
// ----------------------------------------------------------------------------
package lsps_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRAVITY     = 2'd0;
  localparam logic [1:0] CFG_PITCH_LOWER = 2'd1;
  localparam logic [1:0] CFG_PITCH_UPPER = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0]        GRAVITY_RST     = 16'd9810;
  localparam logic signed [17:0] PITCH_LOWER_RST = -18'sd17157;
  localparam logic signed [17:0] PITCH_UPPER_RST = 18'sd45752;

  // Pitch clamp, radians in Q16.16, and flight time ceiling in microseconds.
  localparam logic signed [19:0] PITCH_MAX = 20'sd102944;
  localparam logic [23:0]        TIME_MAX  = 24'hFFFFFF;

  // Microseconds per second.
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // atan(2^-i) in Q16.16, rounded.
  function automatic logic [16:0] atan_q16(input int unsigned i);
    logic [16:0] r;
    begin
      case (i)
        0:       r = 17'd51472;
        1:       r = 17'd30386;
        2:       r = 17'd16055;
        3:       r = 17'd8150;
        4:       r = 17'd4091;
        5:       r = 17'd2047;
        6:       r = 17'd1024;
        7:       r = 17'd512;
        8:       r = 17'd256;
        9:       r = 17'd128;
        10:      r = 17'd64;
        11:      r = 17'd32;
        12:      r = 17'd16;
        13:      r = 17'd8;
        14:      r = 17'd4;
        15:      r = 17'd2;
        16:      r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/lsps_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring digit-by-digit method, with a sideband
// that travels alongside the radicand.
// ----------------------------------------------------------------------------
module lsps_isqrt #(
  parameter int RAD_W  = 66,
  parameter int SIDE_W = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      valid_o,
  output logic [RAD_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic                valid_q [ROOT_W];
  logic [REM_W-1:0]    rem_q   [ROOT_W];
  logic [ROOT_W-1:0]   root_q  [ROOT_W];
  logic [RAD_W-1:0]    rad_q   [ROOT_W];
  logic [SIDE_W-1:0]   side_q  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  cat;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign side_in = side_q[j-1];
    end

    // The partial remainder never exceeds twice the partial root, so the
    // top two bits are free to shift out.
    assign cat   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (cat - trial) : cat;
        root_q[j] <= {root_in[ROOT_W-2:0], ge};
        rad_q[j]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule
`default_nettype wire

@@ design/launch_pitch_solver_no_drag_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drag-free launch pitch solver
// Solves the ballistic quadratic for tan(pitch), converts both roots to
// angles and returns the in-limit pitch with the shorter flight time.
// ----------------------------------------------------------------------------
// This unit is a fully pipelined solver that accepts one transaction per
// clock unless held and returns exactly one result transaction for each,
// in order. Its largest parts are the 33-stage square root of the
// discriminant, the 51-stage square root that forms the path length for
// the flight time, one stage per CORDIC iteration and a 24-stage divider
// that yields the flight time bits. The whole pipeline advances together;
// it holds while a result sits in the output register and the downstream
// side is not ready, and it keeps filling while that register is empty or
// being drained. Configuration writes are taken in every cycle and must
// only happen while the unit is idle. Distance, speed or gravity of zero, a
// negative discriminant, or no root within the pitch limits give a result
// with valid_res low and zero data.
// ----------------------------------------------------------------------------
module launch_pitch_solver_no_drag_unit #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [17:0] cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] distance, [31:16] height, [47:32] speed
  input  wire logic [47:0] s_axis_tdata,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [17:0] pitch, [41:18] flight_time, [47:42] zero
  output logic [47:0]      m_axis_tdata,
  // [0] valid_res
  output logic [0:0]       m_axis_tuser
);

  import lsps_pkg::*;

  localparam int N = ANGLE_ITERATIONS;

  // Sideband through the first square root and the angle stages.
  typedef struct packed {
    logic [31:0] q;
    logic [31:0] vg;
    logic        bad;
    logic [33:0] ay0;
    logic [33:0] ay1;
  } ang_side_t;

  typedef struct packed {
    logic [31:0] v2;
    logic [31:0] q;
    logic [31:0] vg;
    logic        bad;
  } disc_side_t;

  // Per-root sideband through the second square root.
  typedef struct packed {
    logic signed [17:0] p;
    logic               ok;
    logic [31:0]        vg;
  } root_side_t;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [15:0]        gravity_q;
  logic signed [17:0] pitch_lo_q;
  logic signed [17:0] pitch_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q  <= GRAVITY_RST;
      pitch_lo_q <= PITCH_LOWER_RST;
      pitch_hi_q <= PITCH_UPPER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRAVITY:     gravity_q  <= cfg_data_i[15:0];
        CFG_PITCH_LOWER: pitch_lo_q <= cfg_data_i;
        CFG_PITCH_UPPER: pitch_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: every stage moves when the output register is free.
  // --------------------------------------------------------------------------
  logic out_v_q;
  logic en;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: input products.
  // --------------------------------------------------------------------------
  logic [15:0] in_d, in_v, in_ah;
  logic [15:0] in_h;
  logic [32:0] in_tg;

  assign in_d  = s_axis_tdata[15:0];
  assign in_h  = s_axis_tdata[31:16];
  assign in_v  = s_axis_tdata[47:32];
  assign in_ah = in_h[15] ? (~in_h + 16'd1) : in_h;
  assign in_tg = 33'({gravity_q, 1'b0}) * 33'(in_ah);

  logic        s1_v_q, s1_hneg_q, s1_bad_q;
  logic [31:0] s1_v2_q, s1_q_q, s1_vg_q, s1_tg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v2_q   <= 32'(in_v) * 32'(in_v);
      s1_q_q    <= 32'(gravity_q) * 32'(in_d);
      s1_vg_q   <= 32'(in_v) * 32'(gravity_q);
      s1_tg_q   <= in_tg[31:0];
      s1_hneg_q <= in_h[15];
      s1_bad_q  <= (in_d == 16'd0) || (in_v == 16'd0) || (gravity_q == 16'd0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: discriminant terms v^4, (g*d)^2 and 2*g*|h|*v^2.
  // --------------------------------------------------------------------------
  logic        s2_v_q, s2_hneg_q, s2_bad_q;
  logic [31:0] s2_v2_q, s2_q_q, s2_vg_q;
  logic [63:0] s2_pos_q, s2_neg_q, s2_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pos_q  <= 64'(s1_v2_q) * 64'(s1_v2_q);
      s2_neg_q  <= 64'(s1_q_q) * 64'(s1_q_q);
      s2_term_q <= 64'(s1_tg_q) * 64'(s1_v2_q);
      s2_v2_q   <= s1_v2_q;
      s2_q_q    <= s1_q_q;
      s2_vg_q   <= s1_vg_q;
      s2_hneg_q <= s1_hneg_q;
      s2_bad_q  <= s1_bad_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the height term joins the side it belongs to.
  // --------------------------------------------------------------------------
  logic        s3_v_q, s3_bad_q;
  logic [31:0] s3_v2_q, s3_q_q, s3_vg_q;
  logic [64:0] s3_pos_q, s3_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pos_q <= s2_hneg_q ? (65'(s2_pos_q) + 65'(s2_term_q)) : 65'(s2_pos_q);
      s3_neg_q <= s2_hneg_q ? 65'(s2_neg_q) : (65'(s2_neg_q) + 65'(s2_term_q));
      s3_v2_q  <= s2_v2_q;
      s3_q_q   <= s2_q_q;
      s3_vg_q  <= s2_vg_q;
      s3_bad_q <= s2_bad_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: discriminant and its sign.
  // --------------------------------------------------------------------------
  logic        s4_v_q;
  logic [64:0] s4_disc_q;
  disc_side_t  s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_disc_q     <= s3_pos_q - s3_neg_q;
      s4_side_q.v2  <= s3_v2_q;
      s4_side_q.q   <= s3_q_q;
      s4_side_q.vg  <= s3_vg_q;
      s4_side_q.bad <= s3_bad_q || (s3_pos_q < s3_neg_q);
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the discriminant.
  // --------------------------------------------------------------------------
  logic        sq1_v;
  logic [32:0] sq1_root;
  disc_side_t  sq1_side;

  lsps_isqrt #(
    .RAD_W  (66),
    .SIDE_W ($bits(disc_side_t))
  ) u_sqrt_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .rad_i   ({1'b0, s4_disc_q}),
    .side_i  (s4_side_q),
    .valid_o (sq1_v),
    .root_o  (sq1_root),
    .side_o  (sq1_side)
  );

  // --------------------------------------------------------------------------
  // Stage 5: the two numerators and the CORDIC start vectors.
  // --------------------------------------------------------------------------
  logic signed [34:0] num0, num1;
  logic [33:0]        ay0, ay1;

  assign num0 = 35'(sq1_side.v2) + 35'(sq1_root);
  assign num1 = 35'(sq1_side.v2) - 35'(sq1_root);
  assign ay0  = num0[34] ? 34'(-num0) : num0[33:0];
  assign ay1  = num1[34] ? 34'(-num1) : num1[33:0];

  // Normalization registers, one row per stage, one column per root.
  logic               nv_q   [7];
  logic signed [43:0] nx_q   [7][2];
  logic signed [43:0] ny_q   [7][2];
  logic [41:0]        nm_q   [7][2];
  ang_side_t          nside_q[7];

  // CORDIC registers.
  logic               cv_q   [N+1];
  logic signed [43:0] cx_q   [N+1][2];
  logic signed [43:0] cy_q   [N+1][2];
  logic signed [19:0] cz_q   [N+1][2];
  ang_side_t          cside_q[N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q[0] <= 1'b0;
    end else if (en) begin
      nv_q[0] <= sq1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q[0][0]     <= 44'(sq1_side.q);
      nx_q[0][1]     <= 44'(sq1_side.q);
      ny_q[0][0]     <= 44'(num0);
      ny_q[0][1]     <= 44'(num1);
      nm_q[0][0]     <= (34'(sq1_side.q) > ay0) ? 42'(sq1_side.q) : 42'(ay0);
      nm_q[0][1]     <= (34'(sq1_side.q) > ay1) ? 42'(sq1_side.q) : 42'(ay1);
      nside_q[0].q   <= sq1_side.q;
      nside_q[0].vg  <= sq1_side.vg;
      nside_q[0].bad <= sq1_side.bad;
      nside_q[0].ay0 <= ay0;
      nside_q[0].ay1 <= ay1;
    end
  end

  // --------------------------------------------------------------------------
  // Normalization: scale both vectors up until the larger component reaches
  // 2^40. Six stages find the largest shift that stays below 2^40, and a
  // last one adds the final doubling.
  // --------------------------------------------------------------------------
  for (genvar j = 1; j <= 7; j++) begin : g_norm
    localparam int SH  = (j < 7) ? (64 >> j) : 1;
    localparam int LIM = (j < 7) ? (40 - SH) : 40;

    logic               go   [2];
    logic signed [43:0] x_nx [2];
    logic signed [43:0] y_nx [2];
    logic [41:0]        m_nx [2];

    for (genvar k = 0; k < 2; k++) begin : g_lane
      assign go[k]   = ((nm_q[j-1][k] >> LIM) == 42'd0);
      assign x_nx[k] = go[k] ? (nx_q[j-1][k] <<< SH) : nx_q[j-1][k];
      assign y_nx[k] = go[k] ? (ny_q[j-1][k] <<< SH) : ny_q[j-1][k];
      assign m_nx[k] = go[k] ? (nm_q[j-1][k] << SH) : nm_q[j-1][k];
    end

    if (j < 7) begin : g_mid
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          nv_q[j] <= 1'b0;
        end else if (en) begin
          nv_q[j] <= nv_q[j-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          for (int k = 0; k < 2; k++) begin
            nx_q[j][k] <= x_nx[k];
            ny_q[j][k] <= y_nx[k];
            nm_q[j][k] <= m_nx[k];
          end
          nside_q[j] <= nside_q[j-1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cv_q[0] <= 1'b0;
        end else if (en) begin
          cv_q[0] <= nv_q[j-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          for (int k = 0; k < 2; k++) begin
            cx_q[0][k] <= x_nx[k];
            cy_q[0][k] <= y_nx[k];
            cz_q[0][k] <= '0;
          end
          cside_q[0] <= nside_q[j-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC vectoring, one iteration per stage.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [19:0] ANG = 20'(atan_q16(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 2; k++) begin
          if (!cy_q[i][k][43]) begin
            cx_q[i+1][k] <= cx_q[i][k] + (cy_q[i][k] >>> i);
            cy_q[i+1][k] <= cy_q[i][k] - (cx_q[i][k] >>> i);
            cz_q[i+1][k] <= cz_q[i][k] + ANG;
          end else begin
            cx_q[i+1][k] <= cx_q[i][k] - (cy_q[i][k] >>> i);
            cy_q[i+1][k] <= cy_q[i][k] + (cx_q[i][k] >>> i);
            cz_q[i+1][k] <= cz_q[i][k] - ANG;
          end
        end
        cside_q[i+1] <= cside_q[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Limit stage: clamp the angle, check it against the limits, and form the
  // squares for the path length.
  // --------------------------------------------------------------------------
  logic signed [19:0] zc [2];
  logic signed [17:0] pc [2];

  for (genvar k = 0; k < 2; k++) begin : g_clamp
    assign zc[k] = (cz_q[N][k] > PITCH_MAX)  ? PITCH_MAX  :
                   (cz_q[N][k] < -PITCH_MAX) ? -PITCH_MAX : cz_q[N][k];
    assign pc[k] = zc[k][17:0];
  end

  logic               l_v_q;
  logic signed [17:0] l_p_q  [2];
  logic               l_ok_q [2];
  logic [63:0]        l_qq_q;
  logic [67:0]        l_aa_q [2];
  logic [31:0]        l_vg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_v_q <= 1'b0;
    end else if (en) begin
      l_v_q <= cv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        l_p_q[k]  <= pc[k];
        l_ok_q[k] <= !cside_q[N].bad && (pc[k] >= pitch_lo_q) && (pc[k] <= pitch_hi_q);
      end
      l_qq_q    <= 64'(cside_q[N].q) * 64'(cside_q[N].q);
      l_aa_q[0] <= 68'(cside_q[N].ay0) * 68'(cside_q[N].ay0);
      l_aa_q[1] <= 68'(cside_q[N].ay1) * 68'(cside_q[N].ay1);
      l_vg_q    <= cside_q[N].vg;
    end
  end

  // --------------------------------------------------------------------------
  // Radicand stage: (q^2 + y^2) * 2^32.
  // --------------------------------------------------------------------------
  logic        f_v_q;
  logic [68:0] f_sum_q [2];
  root_side_t  f_side_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= l_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        f_sum_q[k]     <= 69'(l_qq_q) + 69'(l_aa_q[k]);
        f_side_q[k].p  <= l_p_q[k];
        f_side_q[k].ok <= l_ok_q[k];
        f_side_q[k].vg <= l_vg_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Path length square roots, one per root.
  // --------------------------------------------------------------------------
  logic        sq2_v    [2];
  logic [50:0] sq2_root [2];
  root_side_t  sq2_side [2];

  for (genvar k = 0; k < 2; k++) begin : g_path
    lsps_isqrt #(
      .RAD_W  (102),
      .SIDE_W ($bits(root_side_t))
    ) u_sqrt_path (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (f_v_q),
      .rad_i   ({1'b0, f_sum_q[k], 32'd0}),
      .side_i  (f_side_q[k]),
      .valid_o (sq2_v[k]),
      .root_o  (sq2_root[k]),
      .side_o  (sq2_side[k])
    );
  end

  // --------------------------------------------------------------------------
  // Scale by 10^6 in two partial products; the distance cancels from the
  // flight time quotient, so the divisor is v*g*2^16.
  // --------------------------------------------------------------------------
  logic        m1_v_q;
  logic [45:0] m1_lo_q [2];
  logic [44:0] m1_hi_q [2];
  root_side_t  m1_side_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= sq2_v[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        m1_lo_q[k]   <= 46'(US_PER_S) * 46'(sq2_root[k][25:0]);
        m1_hi_q[k]   <= 45'(US_PER_S) * 45'(sq2_root[k][50:26]);
        m1_side_q[k] <= sq2_side[k];
      end
    end
  end

  logic        m2_v_q;
  logic [70:0] m2_num_q [2];
  root_side_t  m2_side_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        m2_num_q[k]  <= {m1_hi_q[k][44:0], 26'd0} + 71'(m1_lo_q[k]);
        m2_side_q[k] <= m1_side_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: saturation check, then one quotient bit per stage.
  // --------------------------------------------------------------------------
  logic               dv_q   [25];
  logic [70:0]        dr_q   [25][2];
  logic [23:0]        dq_q   [25][2];
  logic               dsat_q [25][2];
  logic               dok_q  [25][2];
  logic signed [17:0] dp_q   [25][2];
  logic [47:0]        dm_q   [25];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        dr_q[0][k]   <= m2_num_q[k];
        dq_q[0][k]   <= '0;
        dsat_q[0][k] <= (72'(m2_num_q[k]) >= {m2_side_q[0].vg, 40'd0});
        dok_q[0][k]  <= m2_side_q[k].ok;
        dp_q[0][k]   <= m2_side_q[k].p;
      end
      dm_q[0] <= {m2_side_q[0].vg, 16'd0};
    end
  end

  for (genvar j = 0; j < 24; j++) begin : g_div
    localparam int BIT = 23 - j;

    logic [70:0] sub;
    logic        ge [2];

    assign sub = 71'(dm_q[j]) << BIT;
    for (genvar k = 0; k < 2; k++) begin : g_lane
      assign ge[k] = (dr_q[j][k] >= sub);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 2; k++) begin
          dr_q[j+1][k]   <= ge[k] ? (dr_q[j][k] - sub) : dr_q[j][k];
          dq_q[j+1][k]   <= {dq_q[j][k][22:0], ge[k]};
          dsat_q[j+1][k] <= dsat_q[j][k];
          dok_q[j+1][k]  <= dok_q[j][k];
          dp_q[j+1][k]   <= dp_q[j][k];
        end
        dm_q[j+1] <= dm_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Selection and output register. The "+sqrt" root wins on equal times.
  // --------------------------------------------------------------------------
  logic [23:0] t_sel [2];
  logic        pick1, found;

  assign t_sel[0] = dsat_q[24][0] ? TIME_MAX : dq_q[24][0];
  assign t_sel[1] = dsat_q[24][1] ? TIME_MAX : dq_q[24][1];
  assign pick1    = dok_q[24][1] && (!dok_q[24][0] || (t_sel[1] < t_sel[0]));
  assign found    = dok_q[24][0] || dok_q[24][1];

  logic               out_res_q;
  logic signed [17:0] out_p_q;
  logic [23:0]        out_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= found;
      out_p_q   <= !found ? '0 : (pick1 ? dp_q[24][1] : dp_q[24][0]);
      out_t_q   <= !found ? '0 : (pick1 ? t_sel[1] : t_sel[0]);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_t_q, out_p_q};
  assign m_axis_tuser  = out_res_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_pitch_in_limits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_res_q) |-> ((out_p_q >= pitch_lo_q) && (out_p_q <= pitch_hi_q)))
    else $error("reported pitch lies outside the configured limits");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_res_q) |-> ((out_p_q == '0) && (out_t_q == '0)))
    else $error("invalid result carries nonzero data");

  a_pitch_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((20'(out_p_q) <= PITCH_MAX) && (20'(out_p_q) >= -PITCH_MAX)))
    else $error("pitch beyond clamp range");

  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq2_v[0] == sq2_v[1])
    else $error("root lanes out of step");

endmodule
`default_nettype wire

@@ test/launch_pitch_solver_no_drag_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Launch pitch solver testbench
// Streams target queries through the drag-free pitch solver under several
// gravity and pitch-limit settings. A local predictor works out each result
// from the query and the current settings, and every returned transaction
// is checked against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module launch_pitch_solver_no_drag_unit_test;
  import lsps_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index that the unit ignores
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLD_CYCLES = 600;
  localparam int         RANDOM_PER_PHASE = 330;

  typedef struct packed {
    logic               ok;
    logic signed [17:0] pitch;
    logic [23:0]        ftime;
  } solution_t;

  typedef struct {
    logic [15:0]        distance;
    logic signed [15:0] hgt;
    logic [15:0]        spd;
    bit                 typed;  // expected result written in the row
    solution_t          sol;
  } query_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  launch_pitch_solver_no_drag_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Our own copy of the configuration registers.
  logic [15:0]        grav_q = GRAVITY_RST;
  logic signed [17:0] lower_q = PITCH_LOWER_RST;
  logic signed [17:0] upper_q = PITCH_UPPER_RST;

  solution_t pending_solutions[$];
  // Rows with a typed-in answer are compared against it as well.
  bit        typed_flags[$];
  solution_t typed_answers[$];

  bit failed = 1'b0;
  bit hold_request = 1'b0;
  bit back_to_back = 1'b0;
  int idle_cycles = 0;

  // atan(2^-i) in Q16.16, rounded.
  int atan_steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2, 1};

  function automatic logic [63:0] int_sqrt(input logic [127:0] n);
    logic [63:0] root;
    logic [63:0] cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= n) root = cand;
    end
    return root;
  endfunction

  // Vectoring CORDIC; x is positive. Operands are normalized up to 2^40
  // so the shifts keep enough precision.
  function automatic longint pitch_of(input longint x0, input longint y0);
    longint x, y, z, m, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    m = (y < 0) ? -y : y;
    if (x > m) m = x;
    while (m < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_steps[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_steps[i];
      end
    end
    if (z > 102944) z = 102944;
    if (z < -102944) z = -102944;
    return z;
  endfunction

  // Time of flight d / (v cos) in microseconds, with cos taken from the
  // path length sqrt(q^2 + y^2); saturates at the 24-bit ceiling.
  function automatic logic [23:0] flight_time_us(input logic [63:0] d, input logic [63:0] v,
                                                 input logic [63:0] q, input logic [63:0] ay);
    logic [127:0] path_sq, t;
    logic [63:0] path, den, num;
    path_sq = (128'(q) * 128'(q) + 128'(ay) * 128'(ay)) << 32;
    path = int_sqrt(path_sq);
    num = 64'd1000000 * d;
    den = v * q;
    t = (128'(num) * 128'(path)) / 128'(den);
    t = t >> 16;
    if (t > 128'(TIME_MAX)) return TIME_MAX;
    return t[23:0];
  endfunction

  function automatic solution_t solve_pitch(input logic [15:0] distance,
                                            input logic signed [15:0] hgt,
                                            input logic [15:0] spd);
    solution_t sol;
    logic [63:0] d, v, g, v2, q, ah, sroot, ay;
    logic [127:0] pos, neg, term;
    longint roots[2];
    longint p;
    logic [23:0] t, best_t;
    bit found;
    sol = '0;
    found = 1'b0;
    best_t = '0;
    d = 64'(distance);
    v = 64'(spd);
    g = 64'(grav_q);
    if (d == 0 || v == 0 || g == 0) return sol;
    v2 = v * v;
    q = g * d;
    ah = (hgt < 0) ? 64'(-longint'(hgt)) : 64'(longint'(hgt));
    pos = 128'(v2) * 128'(v2);
    neg = 128'(q) * 128'(q);
    term = 128'(64'd2 * g * ah) * 128'(v2);
    if (hgt < 0) pos = pos + term;
    else neg = neg + term;
    if (pos < neg) return sol;
    sroot = int_sqrt(pos - neg);
    roots[0] = longint'(v2 + sroot);
    roots[1] = longint'(v2) - longint'(sroot);
    // The +sqrt root is tried first, so it keeps the slot on a tie.
    for (int k = 0; k < 2; k++) begin
      p = pitch_of(longint'(q), roots[k]);
      if (p < longint'(lower_q) || p > longint'(upper_q)) continue;
      ay = (roots[k] < 0) ? 64'(-roots[k]) : 64'(roots[k]);
      t = flight_time_us(d, v, q, ay);
      if (!found || t < best_t) begin
        found = 1'b1;
        best_t = t;
        sol.pitch = p[17:0];
      end
    end
    if (found) begin
      sol.ok = 1'b1;
      sol.ftime = best_t;
    end
    return sol;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Monitor: predicts every accepted query, tracks register writes and
  // checks every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    solution_t want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRAVITY: begin
          grav_q <= cfg_data_i[15:0];
        end
        CFG_PITCH_LOWER: begin
          lower_q <= cfg_data_i;
        end
        CFG_PITCH_UPPER: begin
          upper_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      pending_solutions.push_back(solve_pitch(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                              s_axis_tdata[47:32]));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_solutions.size() == 0) begin
        $error("result transaction arrived with no query outstanding");
        failed = 1'b1;
      end else begin
        want = pending_solutions.pop_front();
        compare_field("valid_res", want.ok, m_axis_tuser[0]);
        compare_field("pitch", unsigned'(want.pitch), m_axis_tdata[17:0]);
        compare_field("flight_time", want.ftime, m_axis_tdata[41:18]);
        if (typed_flags.size() != 0) begin
          if (typed_flags.pop_front()) begin
            want = typed_answers.pop_front();
            compare_field("valid_res (typed)", want.ok, m_axis_tuser[0]);
            compare_field("pitch (typed)", unsigned'(want.pitch), m_axis_tdata[17:0]);
            compare_field("flight_time (typed)", want.ftime, m_axis_tdata[41:18]);
          end
        end
      end
    end
  end

  // Watchdog: a run of cycles without a single accepted transaction that
  // reaches the limit means the unit has locked up.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: random stalls, runs of full throughput, and one long
  // hold-off that lets the pipeline fill up and push back on the input.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  task automatic send_query(input logic [15:0] distance, input logic signed [15:0] hgt,
                            input logic [15:0] spd);
    int gap;
    gap = (back_to_back || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {spd, hgt, distance};
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_solutions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly reachable targets: distance within the drag-free range v^2/g
  // and a modest height, so both roots show up. The rest is raw noise.
  task automatic random_queries(input int count);
    logic [15:0] distance, spd;
    logic signed [15:0] hgt;
    longint reach;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 6 && grav_q != 0) begin
        spd = (n % 8 == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(200, 40000));
        reach = (longint'(spd) * spd) / grav_q;
        if (reach > 65535) reach = 65535;
        if (reach < 1) reach = 1;
        distance = 16'($urandom_range(1, int'(reach)));
        hgt = 16'(int'($urandom_range(0, 2 * int'(distance[15:2]) + 2)) -
                  int'(distance[15:2]) - 1);
      end else begin
        distance = 16'($urandom);
        hgt = 16'($urandom);
        spd = 16'($urandom);
      end
      send_query(distance, hgt, spd);
    end
  endtask

  query_row_t directed_rows[$];

  function automatic query_row_t row(input logic [15:0] d, input logic signed [15:0] h,
                                     input logic [15:0] v, input bit typed);
    query_row_t r;
    r.distance = d;
    r.hgt = h;
    r.spd = v;
    r.typed = typed;
    r.sol = '0;  // every typed row here expects an invalid, all-zero result
    return r;
  endfunction

  initial begin
    // Invalid inputs: zero distance, zero speed, unreachable target.
    directed_rows.push_back(row(16'd0, 16'sd0, 16'd20000, 1'b1));
    directed_rows.push_back(row(16'd1000, 16'sd0, 16'd0, 1'b1));
    directed_rows.push_back(row(16'd0, -16'sd32768, 16'd0, 1'b1));
    directed_rows.push_back(row(16'd65535, 16'sd0, 16'd1, 1'b1));
    directed_rows.push_back(row(16'd65535, 16'sd32767, 16'd100, 1'b1));
    // Extremes of the fields and ordinary shots.
    directed_rows.push_back(row(16'd65535, -16'sd32768, 16'd65535, 1'b0));
    directed_rows.push_back(row(16'd65535, 16'sd32767, 16'd65535, 1'b0));
    directed_rows.push_back(row(16'd1, 16'sd0, 16'd65535, 1'b0));
    directed_rows.push_back(row(16'd1, 16'sd32767, 16'd65535, 1'b0));
    directed_rows.push_back(row(16'd1, -16'sd32768, 16'd1, 1'b0));
    directed_rows.push_back(row(16'd10000, 16'sd500, 16'd25000, 1'b0));
    directed_rows.push_back(row(16'd20000, -16'sd3000, 16'd15000, 1'b0));
    // Very slow shots at targets far below the launch point.
    directed_rows.push_back(row(16'd1, -16'sd32768, 16'd100, 1'b0));
    directed_rows.push_back(row(16'd2, -16'sd20000, 16'd150, 1'b0));
    // A level shot just beyond the reachable limit.
    directed_rows.push_back(row(16'd40000, 16'sd0, 16'd19800, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      typed_flags.push_back(directed_rows[i].typed);
      if (directed_rows[i].typed) typed_answers.push_back(directed_rows[i].sol);
      send_query(directed_rows[i].distance, directed_rows[i].hgt, directed_rows[i].spd);
    end
    random_queries(RANDOM_PER_PHASE);

    // Back-to-back queries against a stalled result side.
    back_to_back = 1'b1;
    hold_request = 1'b1;
    random_queries(400);
    back_to_back = 1'b0;
    drain_results();

    // Weakest nonzero gravity and the widest pitch window.
    write_reg(CFG_GRAVITY, 18'd1);
    write_reg(CFG_PITCH_LOWER, -18'sd102944);
    write_reg(CFG_PITCH_UPPER, 18'sd102944);
    random_queries(RANDOM_PER_PHASE);
    drain_results();

    // Strongest gravity, narrow window; the unused index must be ignored.
    write_reg(CFG_GRAVITY, 18'd65535);
    write_reg(CFG_PITCH_LOWER, 18'sd0);
    write_reg(CFG_PITCH_UPPER, 18'sd30000);
    write_reg(CFG_UNUSED, 18'h3FFFF);
    random_queries(RANDOM_PER_PHASE);
    drain_results();

    // Lower limit above the upper one: nothing can pass.
    write_reg(CFG_GRAVITY, 18'd9810);
    write_reg(CFG_PITCH_LOWER, 18'sd102944);
    write_reg(CFG_PITCH_UPPER, -18'sd102944);
    random_queries(60);
    drain_results();

    // Zero gravity always gives an invalid result.
    write_reg(CFG_GRAVITY, 18'd0);
    write_reg(CFG_PITCH_LOWER, -18'sd102944);
    write_reg(CFG_PITCH_UPPER, 18'sd102944);
    random_queries(60);
    drain_results();

    // Random settings, with stray upper bits on the gravity write.
    write_reg(CFG_GRAVITY, 18'($urandom_range(1, 262143)) | 18'd1);
    write_reg(CFG_PITCH_LOWER, 18'(int'($urandom_range(0, 102944)) - 102944));
    write_reg(CFG_PITCH_UPPER, 18'($urandom_range(0, 102944)));
    random_queries(RANDOM_PER_PHASE);

    // Let any stray result show up after the last expected one.
    drain_results();
    repeat (150) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lsps_pkg.sv
design/lsps_isqrt.sv
design/launch_pitch_solver_no_drag_unit.sv
test/launch_pitch_solver_no_drag_unit_test.sv
